### sv/neighbor_table_lru_aging_assert.svh
// ----------------------------------------------------------------------------
// Neighbor table assertion macros
// Shared property forms for the neighbor table checkers.
// ----------------------------------------------------------------------------
`ifndef NEIGHBOR_TABLE_LRU_AGING_ASSERT_SVH
`define NEIGHBOR_TABLE_LRU_AGING_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define NTLA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define NTLA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/ntla_pkg.sv
// ----------------------------------------------------------------------------
// Neighbor table package
// Sizes, field widths, command and status codes and entry layout.
// ----------------------------------------------------------------------------
package ntla_pkg;

   // Table size and derived widths
   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // Transaction field widths
   localparam int CMD_W    = 2;
   localparam int ID_W     = 8;
   localparam int STR_W    = 8;
   localparam int HOP_W    = 8;
   localparam int TIME_W   = 32;
   localparam int RIDX_W   = 4;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 4;
   localparam int COUNT_W  = 5;

   localparam logic [TIME_W-1:0] AGE_LIMIT_RESET = TIME_W'(1000);

   typedef enum logic [CMD_W-1:0] {
      CMD_UPDATE = 2'd0,
      CMD_PURGE  = 2'd1,
      CMD_READ   = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_REFRESHED = 3'd0,
      ST_INSERTED  = 3'd1,
      ST_REPLACED  = 3'd2,
      ST_PURGED    = 3'd3,
      ST_READ_OK   = 3'd4,
      ST_READ_OOR  = 3'd5
   } status_type;

   // One table entry as stored in the RAM
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [STR_W-1:0]  strength;
      logic [HOP_W-1:0]  hops;
      logic [TIME_W-1:0] stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Pending result, count is taken when the result is issued
   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] slot;
      entry_type         entry;
   } result_type;

endpackage

### sv/ntla_if.sv
// ----------------------------------------------------------------------------
// Neighbor table channel interfaces
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ntla_req_if;
   import ntla_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         command;
   logic [ID_W-1:0]          neighbor_id;
   logic signed [STR_W-1:0]  signal_strength;
   logic [HOP_W-1:0]         hops;
   logic [TIME_W-1:0]        now_time;
   logic [RIDX_W-1:0]        read_index;

   modport source (output valid, command, neighbor_id, signal_strength, hops, now_time,
                   read_index, input ready);
   modport sink   (input valid, command, neighbor_id, signal_strength, hops, now_time,
                   read_index, output ready);
endinterface

interface ntla_rsp_if;
   import ntla_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic [SLOT_W-1:0]        slot;
   logic [COUNT_W-1:0]       table_count;
   logic [ID_W-1:0]          entry_id;
   logic signed [STR_W-1:0]  entry_strength;
   logic [HOP_W-1:0]         entry_hops;
   logic [TIME_W-1:0]        entry_time;

   modport source (output valid, status, slot, table_count, entry_id, entry_strength,
                   entry_hops, entry_time, input ready);
   modport sink   (input valid, status, slot, table_count, entry_id, entry_strength,
                   entry_hops, entry_time, output ready);
endinterface

interface ntla_csr_if;
   import ntla_pkg::*;

   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

### sv/neighbor_table_lru_aging.sv
// ----------------------------------------------------------------------------
// Neighbor table with least-recently-updated replacement and aging
// Sequencer around one table RAM: update, purge and read transactions.
// ----------------------------------------------------------------------------
// One request transaction is taken at a time; req_bus.ready is high only while
// the sequencer is idle, and a finished result sits in the response register
// so the next request can be taken while it waits. The table RAM has a single
// read port, so entries are read one at a time: an update scans the live
// entries in order until it finds its id, and an update with a new id scans
// all live entries, then appends or overwrites the oldest entry; purge reads
// each live entry and moves the last entry into each removed one; a read
// issues its table read when it is accepted if the index is below the count.
// A result that finds the response register still full holds the sequencer,
// and with it the request channel, until the register frees. Command code 3
// is taken and dropped without a response. age_limit is to be written through
// csr_bus only while the block is idle; the block itself does not enforce it.
module neighbor_table_lru_aging (
   input  logic          clock,
   input  logic          reset,
   ntla_req_if.sink      req_bus,
   ntla_rsp_if.source    rsp_bus,
   ntla_csr_if.sink      csr_bus
);
   import ntla_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_UPD_RD  = 7'b0000010,
      S_UPD_CHK = 7'b0000100,
      S_PRG_RD  = 7'b0001000,
      S_PRG_CHK = 7'b0010000,
      S_PRG_MOV = 7'b0100000,
      S_RESP    = 7'b1000000
   } state_type;

   // Sequencer state
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [TIME_W-1:0]    age_limit_ff;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [TIME_W-1:0]    best_time_ff, best_time_in;
   logic                 read_pend_ff, read_pend_in;
   entry_type            req_ff, req_in;
   result_type           res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_ff, rsp_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   // RAM port
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   entry_type            wr_data;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   entry_type            rd_data;
   logic [ENTRY_W-1:0]   rd_raw;

   logic                 req_fire;
   logic                 rsp_free;
   logic [TIME_W-1:0]    age;
   logic [CNT_W-1:0]     last_idx;

   ntla_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_data  = entry_type'(rd_raw);
   assign req_fire = req_bus.valid && req_bus.ready;
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;
   assign age      = req_ff.stamp - rd_data.stamp;
   assign last_idx = count_ff - CNT_W'(1);

   // Handshake outputs
   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = rsp_ff.status;
   assign rsp_bus.slot           = rsp_ff.slot;
   assign rsp_bus.table_count    = rsp_count_ff;
   assign rsp_bus.entry_id       = rsp_ff.entry.id;
   assign rsp_bus.entry_strength = $signed(rsp_ff.entry.strength);
   assign rsp_bus.entry_hops     = rsp_ff.entry.hops;
   assign rsp_bus.entry_time     = rsp_ff.entry.stamp;

   // Sequence one transaction through the table
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      best_idx_in  = best_idx_ff;
      best_time_in = best_time_ff;
      read_pend_in = 1'b0;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_count_in = rsp_count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[IDX_W-1:0];
      wr_data      = req_ff;
      rd_en        = 1'b0;
      rd_addr      = idx_ff[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               req_in.id       = req_bus.neighbor_id;
               req_in.strength = req_bus.signal_strength;
               req_in.hops     = req_bus.hops;
               req_in.stamp    = req_bus.now_time;
               idx_in          = '0;
               res_in          = '0;
               case (req_bus.command)
                  CMD_UPDATE: state_in = S_UPD_RD;
                  CMD_PURGE:  state_in = S_PRG_RD;
                  CMD_READ: begin
                     // Issue the read at once when the index is live
                     if (CNT_W'(req_bus.read_index) < count_ff) begin
                        rd_en        = 1'b1;
                        rd_addr      = IDX_W'(req_bus.read_index);
                        read_pend_in = 1'b1;
                     end else begin
                        res_in.status = ST_READ_OOR;
                     end
                     state_in = S_RESP;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end

         S_UPD_RD: begin
            if (idx_ff < count_ff) begin
               rd_en    = 1'b1;
               state_in = S_UPD_CHK;
            end else begin
               // Id not present: append or overwrite the oldest entry
               wr_en = 1'b1;
               if (count_ff < CNT_W'(TABLE_DEPTH)) begin
                  wr_addr       = count_ff[IDX_W-1:0];
                  res_in.slot   = SLOT_W'(count_ff[IDX_W-1:0]);
                  res_in.status = ST_INSERTED;
                  count_in      = count_ff + CNT_W'(1);
               end else begin
                  wr_addr       = best_idx_ff;
                  res_in.slot   = SLOT_W'(best_idx_ff);
                  res_in.status = ST_REPLACED;
               end
               state_in = S_RESP;
            end
         end

         S_UPD_CHK: begin
            if (rd_data.id == req_ff.id) begin
               wr_en         = 1'b1;
               res_in.slot   = SLOT_W'(idx_ff[IDX_W-1:0]);
               res_in.status = ST_REFRESHED;
               state_in      = S_RESP;
            end else begin
               // Track the lowest stamp, first index wins a tie
               if (idx_ff == '0 || rd_data.stamp < best_time_ff) begin
                  best_idx_in  = idx_ff[IDX_W-1:0];
                  best_time_in = rd_data.stamp;
               end
               idx_in   = idx_ff + CNT_W'(1);
               state_in = S_UPD_RD;
            end
         end

         S_PRG_RD: begin
            if (idx_ff < count_ff) begin
               rd_en    = 1'b1;
               state_in = S_PRG_CHK;
            end else begin
               res_in.status = ST_PURGED;
               state_in      = S_RESP;
            end
         end

         S_PRG_CHK: begin
            // Fetch the last live entry in case this one must go
            rd_en   = 1'b1;
            rd_addr = last_idx[IDX_W-1:0];
            if (age > age_limit_ff) begin
               state_in = S_PRG_MOV;
            end else begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = S_PRG_RD;
            end
         end

         S_PRG_MOV: begin
            // Move the last entry into the stale slot and recheck it
            wr_en    = 1'b1;
            wr_data  = rd_data;
            count_in = last_idx;
            state_in = S_PRG_RD;
         end

         S_RESP: begin
            if (rsp_free) begin
               rsp_in = res_ff;
               if (read_pend_ff) begin
                  rsp_in.entry  = rd_data;
                  rsp_in.status = ST_READ_OK;
               end
               rsp_count_in = COUNT_W'(count_ff);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               read_pend_in = read_pend_ff;
               if (read_pend_ff) begin
                  res_in.entry  = rd_data;
                  res_in.status = ST_READ_OK;
               end
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         age_limit_ff <= AGE_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
         read_pend_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         read_pend_ff <= read_pend_in;
         if (csr_bus.valid && csr_bus.ready) begin
            age_limit_ff <= csr_bus.data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      best_idx_ff  <= best_idx_in;
      best_time_ff <= best_time_in;
      req_ff       <= req_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
      rsp_count_ff <= rsp_count_in;
   end
endmodule

### sv/ntla_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ntla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // Write, then registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

### sv/ntla_checker.sv
// ----------------------------------------------------------------------------
// Neighbor table port checker
// Watches the response channel of the neighbor table over time.
// ----------------------------------------------------------------------------
`include "neighbor_table_lru_aging_assert.svh"

module ntla_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [ntla_pkg::STATUS_W-1:0]   rsp_status,
   input logic [ntla_pkg::SLOT_W-1:0]     rsp_slot,
   input logic [ntla_pkg::COUNT_W-1:0]    rsp_table_count,
   input logic [ntla_pkg::ID_W-1:0]       rsp_entry_id,
   input logic [ntla_pkg::TIME_W-1:0]     rsp_entry_time
);
   import ntla_pkg::*;

   logic [COUNT_W-1:0] slot_next;
   logic               count_in_range;
   logic               entry_clear;

   // Derived views of the response
   assign slot_next      = COUNT_W'(rsp_slot) + COUNT_W'(1);
   assign count_in_range = (rsp_table_count <= COUNT_W'(TABLE_DEPTH));
   assign entry_clear    = (rsp_entry_id == '0) && (rsp_entry_time == '0);

   `NTLA_ASSERT_NOW(a_count_range, clock, reset, rsp_valid, count_in_range,
      "table count beyond table depth")

   `NTLA_ASSERT_NOW(a_entry_clear, clock, reset, rsp_valid && rsp_status != ST_READ_OK,
      entry_clear, "entry fields not zero outside a successful read")

   `NTLA_ASSERT_NOW(a_insert_tail, clock, reset, rsp_valid && rsp_status == ST_INSERTED,
      slot_next == rsp_table_count, "inserted slot is not the new last entry")

   `NTLA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status), "stalled response changed")
endmodule

bind neighbor_table_lru_aging ntla_checker u_ntla_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_status      (rsp_bus.status),
   .rsp_slot        (rsp_bus.slot),
   .rsp_table_count (rsp_bus.table_count),
   .rsp_entry_id    (rsp_bus.entry_id),
   .rsp_entry_time  (rsp_bus.entry_time)
);

### bench/neighbor_table_lru_aging_tb.sv
// ----------------------------------------------------------------------------
// Neighbor table testbench
// Drives update, purge and read transactions into the neighbor table and
// compares every response against a cycle-free table predictor. The run
// starts with directed corner cases, then sweeps age limits with random
// traffic, stalls the response side to back up the input, and finishes with
// a run without idle cycles.
// ----------------------------------------------------------------------------
module neighbor_table_lru_aging_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ntla_pkg::*;

   // Command code the block takes and drops without a response
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   // Settling wait, long enough for the longest update or purge
   localparam int SETTLE_CYCLES = 64;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [ID_W-1:0]   neighbor_id;
      logic [STR_W-1:0]  strength;
      logic [HOP_W-1:0]  hops;
      logic [TIME_W-1:0] now_time;
      logic [RIDX_W-1:0] read_index;
   } request_type;

   typedef struct packed {
      status_type         status;
      logic [SLOT_W-1:0]  slot;
      logic [COUNT_W-1:0] count;
      entry_type          entry;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ntla_req_if req_bus ();
   ntla_rsp_if rsp_bus ();
   ntla_csr_if csr_bus ();

   neighbor_table_lru_aging dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Shadow table state
   entry_type          nbr_table [TABLE_DEPTH];
   logic [COUNT_W-1:0] live_entries;
   logic [TIME_W-1:0]  age_limit_q;

   response_type       pending_results [$];
   int                 mismatches      = 0;
   bit                 req_idle_on     = 1'b0;
   bit                 rsp_idle_on     = 1'b0;
   int                 hold_off_cycles = 0;
   logic [TIME_W-1:0]  traffic_time    = '0;

   always #5 clock = ~clock;

   // Apply one transaction to the shadow table; return 1 when it yields a response
   function automatic bit apply_to_table(input request_type rq, output response_type rs);
      int                k;
      int                best;
      int                last;
      bit                found;
      logic [TIME_W-1:0] age;
      rs    = '0;
      found = 1'b0;
      if (rq.command == CMD_UNUSED)
         return 1'b0;
      case (rq.command)
         CMD_UPDATE: begin
            for (k = 0; k < live_entries; k++) begin
               if (!found && nbr_table[k].id == rq.neighbor_id) begin
                  nbr_table[k] = '{rq.neighbor_id, rq.strength, rq.hops, rq.now_time};
                  rs.status    = ST_REFRESHED;
                  rs.slot      = k[SLOT_W-1:0];
                  found        = 1'b1;
               end
            end
            if (!found) begin
               if (live_entries < TABLE_DEPTH) begin
                  k            = int'(live_entries);
                  live_entries = live_entries + 1'b1;
                  rs.status    = ST_INSERTED;
               end else begin
                  // Plain unsigned compare, lowest index wins a tie
                  best = 0;
                  for (k = 1; k < TABLE_DEPTH; k++)
                     if (nbr_table[k].stamp < nbr_table[best].stamp)
                        best = k;
                  k         = best;
                  rs.status = ST_REPLACED;
               end
               nbr_table[k] = '{rq.neighbor_id, rq.strength, rq.hops, rq.now_time};
               rs.slot      = k[SLOT_W-1:0];
            end
         end
         CMD_PURGE: begin
            // Move the last entry into a stale slot and check the slot again
            k = 0;
            while (k < live_entries) begin
               age = rq.now_time - nbr_table[k].stamp;
               if (age > age_limit_q) begin
                  last         = int'(live_entries) - 1;
                  nbr_table[k] = nbr_table[last];
                  live_entries = live_entries - 1'b1;
               end else begin
                  k++;
               end
            end
            rs.status = ST_PURGED;
         end
         default: begin
            if (rq.read_index < live_entries) begin
               rs.status = ST_READ_OK;
               rs.entry  = nbr_table[rq.read_index];
            end else begin
               rs.status = ST_READ_OOR;
            end
         end
      endcase
      rs.count = live_entries;
      return 1'b1;
   endfunction

   function automatic request_type mk_req(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                                          logic [STR_W-1:0] str, logic [HOP_W-1:0] hop,
                                          logic [TIME_W-1:0] now, logic [RIDX_W-1:0] ridx);
      request_type rq;
      rq = '{cmd, id, str, hop, now, ridx};
      return rq;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want,
                  got);
         mismatches++;
      end
   endfunction

   // Offer one transaction, hold it until accepted, then record its prediction
   task automatic send_request(input request_type rq);
      response_type rs;
      @(negedge clock);
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_bus.valid           = 1'b1;
      req_bus.command         = rq.command;
      req_bus.neighbor_id     = rq.neighbor_id;
      req_bus.signal_strength = rq.strength;
      req_bus.hops            = rq.hops;
      req_bus.now_time        = rq.now_time;
      req_bus.read_index      = rq.read_index;
      do @(posedge clock); while (!req_bus.ready);
      if (apply_to_table(rq, rs))
         pending_results.push_back(rs);
   endtask

   task automatic release_request();
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   // Write age_limit once every response is in and the sequencer is quiet
   task automatic write_age_limit(input logic [TIME_W-1:0] limit);
      release_request();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.data  = limit;
      do @(posedge clock); while (!csr_bus.ready);
      age_limit_q = limit;
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Mostly a small id pool so refreshes and replacements are frequent
   function automatic request_type random_request(int step_max);
      request_type rq;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)      rq.command = CMD_UPDATE;
      else if (pick < 70) rq.command = CMD_PURGE;
      else if (pick < 95) rq.command = CMD_READ;
      else                rq.command = CMD_UNUSED;
      if ($urandom_range(0, 49) == 0)
         traffic_time = $urandom();
      else
         traffic_time = traffic_time + $urandom_range(0, step_max);
      rq.neighbor_id = ($urandom_range(0, 5) == 0) ? ID_W'($urandom_range(0, 255))
                                                    : ID_W'($urandom_range(0, 23));
      rq.strength    = STR_W'($urandom_range(0, 255));
      rq.hops        = HOP_W'($urandom_range(0, 255));
      rq.now_time    = traffic_time;
      rq.read_index  = RIDX_W'($urandom_range(0, 15));
      return rq;
   endfunction

   // Send transactions until the given number of responding ones went out
   task automatic run_traffic(input int n, input int step_max);
      request_type rq;
      int          sent;
      sent = 0;
      while (sent < n) begin
         rq = random_request(step_max);
         send_request(rq);
         if (rq.command != CMD_UNUSED)
            sent++;
      end
   endtask

   task automatic test_directed();
      int i;
      send_request(mk_req(CMD_READ, 8'h00, 8'h00, 8'h00, 32'h0, 4'd0));
      send_request(mk_req(CMD_UPDATE, 8'h00, 8'h80, 8'h00, 32'h0, 4'd0));
      send_request(mk_req(CMD_UPDATE, 8'hFF, 8'h7F, 8'hFF, 32'hFFFF_FFFF, 4'hF));
      send_request(mk_req(CMD_UPDATE, 8'h00, 8'h05, 8'h03, 32'd100, 4'd0));
      send_request(mk_req(CMD_READ, 8'h00, 8'h00, 8'h00, 32'h0, 4'd0));
      send_request(mk_req(CMD_READ, 8'h00, 8'h00, 8'h00, 32'h0, 4'd1));
      send_request(mk_req(CMD_READ, 8'h00, 8'h00, 8'h00, 32'h0, 4'd2));
      send_request(mk_req(CMD_UNUSED, 8'hAA, 8'h55, 8'hAA, 32'h5555_AAAA, 4'd5));
      // Fill the table with equal times so the replacement has a tie
      for (i = 1; i <= 14; i++)
         send_request(mk_req(CMD_UPDATE, i[7:0], -i[7:0], i[7:0], 32'd50, 4'd0));
      send_request(mk_req(CMD_READ, 8'h00, 8'h00, 8'h00, 32'h0, 4'd15));
      send_request(mk_req(CMD_UPDATE, 8'hC8, 8'h11, 8'h22, 32'd60, 4'd0));
      // Entry 0 ages exactly to the limit, entry 1 wraps past it
      send_request(mk_req(CMD_PURGE, 8'h00, 8'h00, 8'h00, 32'd1100, 4'd0));
      send_request(mk_req(CMD_READ, 8'h00, 8'h00, 8'h00, 32'h0, 4'd0));
   endtask

   task automatic test_age_limit_phases();
      write_age_limit(32'd0);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      run_traffic(180, 2);
      write_age_limit(32'hFFFF_FFFF);
      rsp_idle_on = 1'b0;
      run_traffic(180, 50);
      write_age_limit(32'd300);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b1;
      run_traffic(180, 30);
      write_age_limit($urandom_range(1, 5000));
      req_idle_on = 1'b1;
      run_traffic(180, int'(age_limit_q / 32'd10) + 1);
   endtask

   // Hold the response side long enough that the input backs up
   task automatic test_input_stall();
      write_age_limit(AGE_LIMIT_RESET);
      req_idle_on     = 1'b0;
      rsp_idle_on     = 1'b0;
      hold_off_cycles = 400;
      run_traffic(60, 100);
   endtask

   task automatic test_closing_run();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      run_traffic(120, 100);
   endtask

   // Response sink: long hold-off when asked, otherwise random stall bursts if rsp_idle_on
   initial begin : response_sink
      int stall_left;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles != 0) begin
            rsp_bus.ready = 1'b0;
            hold_off_cycles--;
         end else if (stall_left != 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else if (rsp_idle_on && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready = 1'b0;
            stall_left    = $urandom_range(1, 6) - 1;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   // Compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      response_type seen;
      response_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen.status         = status_type'(rsp_bus.status);
         seen.slot           = rsp_bus.slot;
         seen.count          = rsp_bus.table_count;
         seen.entry.id       = rsp_bus.entry_id;
         seen.entry.strength = rsp_bus.entry_strength;
         seen.entry.hops     = rsp_bus.entry_hops;
         seen.entry.stamp    = rsp_bus.entry_time;
         if (pending_results.size() == 0) begin
            $display("%0t ns: response with none expected, expected nothing, actual 0x%0h",
                     $time, seen);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", 32'(want.status), 32'(seen.status));
            check_field("slot", 32'(want.slot), 32'(seen.slot));
            check_field("table_count", 32'(want.count), 32'(seen.count));
            check_field("entry_id", 32'(want.entry.id), 32'(seen.entry.id));
            check_field("entry_strength", 32'(want.entry.strength),
                        32'(seen.entry.strength));
            check_field("entry_hops", 32'(want.entry.hops), 32'(seen.entry.hops));
            check_field("entry_time", want.entry.stamp, seen.entry.stamp);
         end
      end
   end

   initial begin : run_limit
      #5_000_000;
      $display("neighbor_table_lru_aging_tb failed");
      $finish;
   end

   initial begin : main_sequence
      int i;
      for (i = 0; i < TABLE_DEPTH; i++)
         nbr_table[i] = '0;
      live_entries            = '0;
      age_limit_q             = AGE_LIMIT_RESET;
      req_bus.valid           = 1'b0;
      req_bus.command         = CMD_UPDATE;
      req_bus.neighbor_id     = '0;
      req_bus.signal_strength = '0;
      req_bus.hops            = '0;
      req_bus.now_time        = '0;
      req_bus.read_index      = '0;
      csr_bus.valid           = 1'b0;
      csr_bus.data            = '0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_age_limit_phases();
      test_input_stall();
      test_closing_run();

      // Drain, then give a stray response time to show up
      release_request();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("neighbor_table_lru_aging_tb passed");
      else
         $display("neighbor_table_lru_aging_tb failed");
      $finish;
   end

endmodule

### filelist.f
+incdir+sv
sv/ntla_pkg.sv
sv/ntla_if.sv
sv/ntla_ram.sv
sv/neighbor_table_lru_aging.sv
sv/ntla_checker.sv
bench/neighbor_table_lru_aging_tb.sv
